// ----- design/bthal_pkg.sv -----
// ----------------------------------------------------------------------------
// bthal_pkg
// shared types and constants of the boundary tag heap allocator
// ----------------------------------------------------------------------------
package bthal_pkg;

    localparam int TAG_W     = 17;   // width of one size tag
    localparam int CNT_W     = 13;   // width of the free chunk counter
    localparam int TAG_BYTES = 4;    // bytes taken by one header or footer tag
    localparam int MIN_CHUNK = 16;   // smallest chunk in bytes
    localparam int TAGS_BYTES = 2 * TAG_BYTES;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_OOM = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_A_FTR,
        S_F_WR_HDR,
        S_F_RD_PFT,
        S_F_RD_PRV,
        S_F_CHK_PRV,
        S_F_WR_PFT,
        S_F_RD_BS,
        S_F_RD_NXT,
        S_F_CHK_NXT,
        S_F_WR_NFT,
        S_DONE
    } t_state;

endpackage

// ----- design/bthal_ram.sv -----
// ----------------------------------------------------------------------------
// bthal_ram
// single port synchronous ram, registered read, one access per cycle
// ----------------------------------------------------------------------------
module bthal_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/boundary_tag_heap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_unit
// boundary tag heap allocator with coalescing of neighboring free chunks
// ----------------------------------------------------------------------------
// One request word in, one result word out. Chunks are placed at the heap top
// like a bump allocator; each chunk holds its size in a header tag at its first
// byte (bit 0 set while in use) and in a footer tag at its last four bytes. All
// tags live in one single-port tag ram with registered read, so the request
// sequencer walks the tag accesses one by one. An allocate holds the sequencer
// through range check plus header write, footer write and result load; out of
// memory skips the footer write. A free holds it through these steps: read and
// flip the header, read the previous footer and header, write the merged tags,
// re-read the own header, read the next header and write the merged tags. The
// previous neighbor reads are skipped for the first chunk, the tag writes of a
// merge only happen when the neighbor is free, and a chunk that ends at the
// top skips the next neighbor read. The next request word is accepted once
// the result is loaded into the output register, even while that result is
// still stalled downstream; a result that finds the output register still full
// waits in the last step and holds off the input for as long. The tag ram has
// no reset and is never cleared: only live payload offsets may be freed.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_unit #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_payload_offset,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_offset,
    output logic        o_status,
    output logic [12:0] o_free_count,
    output logic [16:0] o_top_offset
);

    import bthal_pkg::*;

    // tag ram geometry: one entry per even byte offset
    localparam int DEPTH = HEAP_BYTES / 2;
    localparam int IW    = $clog2(DEPTH);
    // heap top width, able to hold HEAP_BYTES itself
    localparam int TW    = $clog2(HEAP_BYTES + 1);
    // common width of top and tag values
    localparam int MW    = (TW > TAG_W) ? TW : TAG_W;
    // byte address width, one spare bit as sign for header address math
    localparam int AW    = MW + 1;

    // sequencer and heap state
    t_state            r_state, n_state;
    logic [TW-1:0]     r_top, n_top;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // per request work registers
    logic [15:0]       r_size, n_size;
    logic [AW-1:0]     r_hdr, n_hdr;       // header byte address of current chunk
    logic [AW-1:0]     r_prv, n_prv;       // header byte address of previous chunk
    logic [TAG_W-1:0]  r_tag, n_tag;       // own tag value (flipped header, then size)
    logic [TAG_W-1:0]  r_mrg, n_mrg;       // merged size or new chunk size
    logic [15:0]       r_res, n_res;
    logic              r_oom, n_oom;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_o_res;
    logic              r_o_status;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [TAG_W-1:0]  r_o_top;
    logic              out_load;

    // tag ram port
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [TAG_W-1:0]  ram_wdata;
    logic [TAG_W-1:0]  ram_rdata;

    // allocate size arithmetic
    logic [TAG_W-1:0]  size_even;
    logic [TAG_W-1:0]  size_tags;
    logic [TAG_W-1:0]  chunk;
    logic [MW:0]       top_end;
    logic              accept;

    bthal_ram #(
        .WIDTH (TAG_W),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr[IW:1]),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // round up to even, add both tags, enforce minimum chunk
    assign size_even = TAG_W'(r_size) + TAG_W'(r_size[0]);
    assign size_tags = size_even + TAG_W'(TAGS_BYTES);
    assign chunk     = (size_tags < TAG_W'(MIN_CHUNK)) ? TAG_W'(MIN_CHUNK) : size_tags;
    assign top_end   = (MW + 1)'(r_top) + (MW + 1)'(chunk);

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_cnt       = r_cnt;
        n_size      = r_size;
        n_hdr       = r_hdr;
        n_prv       = r_prv;
        n_tag       = r_tag;
        n_mrg       = r_mrg;
        n_res       = r_res;
        n_oom       = r_oom;
        ram_we      = 1'b0;
        ram_addr    = r_hdr;
        ram_wdata   = r_tag;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && i_stall;

        case (r_state)
            S_IDLE: begin
                // issue the header read right away for a free
                ram_addr = AW'(i_payload_offset) - AW'(TAG_BYTES);
                if (accept) begin
                    n_size = i_req_size;
                    n_hdr  = AW'(i_payload_offset) - AW'(TAG_BYTES);
                    n_res  = '0;
                    n_oom  = ST_OK;
                    if (i_req_type == REQ_FREE) begin
                        n_state = S_F_WR_HDR;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end

            S_ALLOC: begin
                n_mrg = chunk;
                if (top_end > (MW + 1)'(HEAP_BYTES)) begin
                    n_oom   = ST_OOM;
                    n_state = S_DONE;
                end else begin
                    // header tag at the top, in-use bit set
                    ram_we    = 1'b1;
                    ram_addr  = AW'(r_top);
                    ram_wdata = chunk | TAG_W'(1);
                    n_res     = 16'(AW'(r_top) + AW'(TAG_BYTES));
                    n_state   = S_A_FTR;
                end
            end

            S_A_FTR: begin
                ram_we    = 1'b1;
                ram_addr  = AW'(r_top) + AW'(r_mrg) - AW'(TAG_BYTES);
                ram_wdata = r_mrg;
                n_top     = r_top + TW'(r_mrg);
                n_state   = S_DONE;
            end

            S_F_WR_HDR: begin
                // clear the in-use bit
                ram_we    = 1'b1;
                ram_addr  = r_hdr;
                ram_wdata = ram_rdata ^ TAG_W'(1);
                n_tag     = ram_rdata ^ TAG_W'(1);
                n_cnt     = r_cnt + CNT_W'(1);
                if ($signed(r_hdr) > $signed(AW'(TAG_BYTES))) begin
                    n_state = S_F_RD_PFT;
                end else begin
                    // first chunk, no previous neighbor
                    n_state = S_F_RD_BS;
                end
            end

            S_F_RD_PFT: begin
                ram_addr = r_hdr - AW'(TAG_BYTES);
                n_state  = S_F_RD_PRV;
            end

            S_F_RD_PRV: begin
                // previous footer arrives, read previous header
                ram_addr = r_hdr - AW'(ram_rdata);
                n_prv    = r_hdr - AW'(ram_rdata);
                n_state  = S_F_CHK_PRV;
            end

            S_F_CHK_PRV: begin
                if (!ram_rdata[0]) begin
                    ram_we    = 1'b1;
                    ram_addr  = r_prv;
                    ram_wdata = ram_rdata + r_tag;
                    n_mrg     = ram_rdata + r_tag;
                    n_hdr     = r_prv;
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_state   = S_F_WR_PFT;
                end else begin
                    n_state = S_F_RD_BS;
                end
            end

            S_F_WR_PFT: begin
                ram_we    = 1'b1;
                ram_addr  = r_hdr + AW'(r_mrg) - AW'(TAG_BYTES);
                ram_wdata = r_mrg;
                n_state   = S_F_RD_BS;
            end

            S_F_RD_BS: begin
                ram_addr = r_hdr;
                n_state  = S_F_RD_NXT;
            end

            S_F_RD_NXT: begin
                n_tag    = ram_rdata;
                ram_addr = r_hdr + AW'(ram_rdata);
                if ((r_hdr + AW'(ram_rdata)) != AW'(r_top)) begin
                    n_state = S_F_CHK_NXT;
                end else begin
                    // chunk ends at the top: give it back to the top
                    n_cnt = r_cnt - CNT_W'(1);
                    if (MW'(ram_rdata) > MW'(r_top)) begin
                        n_top = '0;
                    end else begin
                        n_top = TW'(MW'(r_top) - MW'(ram_rdata));
                    end
                    n_state = S_DONE;
                end
            end

            S_F_CHK_NXT: begin
                if (!ram_rdata[0]) begin
                    ram_we    = 1'b1;
                    ram_addr  = r_hdr;
                    ram_wdata = r_tag + ram_rdata;
                    n_mrg     = r_tag + ram_rdata;
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_state   = S_F_WR_NFT;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_F_WR_NFT: begin
                ram_we    = 1'b1;
                ram_addr  = r_hdr + AW'(r_mrg) - AW'(TAG_BYTES);
                ram_wdata = r_mrg;
                n_state   = S_DONE;
            end

            S_DONE: begin
                // wait for room in the output register
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_hdr  <= n_hdr;
        r_prv  <= n_prv;
        r_tag  <= n_tag;
        r_mrg  <= n_mrg;
        r_res  <= n_res;
        r_oom  <= n_oom;
        if (out_load) begin
            r_o_res    <= r_res;
            r_o_status <= r_oom;
            r_o_cnt    <= r_cnt;
            r_o_top    <= TAG_W'(r_top);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_offset = r_o_res;
    assign o_status        = r_o_status;
    assign o_free_count    = r_o_cnt;
    assign o_top_offset    = r_o_top;

endmodule
